// File: sv/assert_macros.svh
// Assertion macros shared by the bounce unit's modules.
// Each use names a label, a property and a message; clk_i and rst_ni must exist.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge, not during reset.
`define SBB_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition in one cycle leads to a consequence in the next.
`define SBB_ASSERT_NEXT(name, ante, cons, msg) \
  `SBB_ASSERT(name, (ante) |=> (cons), msg)

`endif

// File: sv/sbb_pkg.sv
// Shared widths, types and constants of the segment ball bounce unit.
// Depends on nothing; every other file but the assertion header refers to it by scoped names.
package sbb_pkg;

  localparam int PosW      = 24;
  localparam int VelW      = 24;
  localparam int RadW      = 16;
  localparam int RestW     = 15;
  localparam int KickW     = 4;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 24;

  localparam int DW        = 25;  // endpoint and offset differences
  localparam int ProdW     = 50;  // product of two differences
  localparam int VProdW    = 49;  // velocity times difference
  localparam int TW        = 50;  // tangential and normal dot products
  localparam int DotW      = 51;
  localparam int DdW       = 50;  // squared segment length
  localparam int CrW       = 50;  // magnitude of the cross product
  localparam int HalfW     = 25;
  localparam int RrW       = 32;
  localparam int Cr2W      = 100;
  localparam int RdW       = 82;
  localparam int EnW       = 66;  // restitution times normal part
  localparam int TdW       = 75;
  localparam int EdW       = 91;
  localparam int NumW      = 92;
  localparam int RemW      = 79;  // rounded numerator after dropping 14 bits
  localparam int QuoW      = 26;  // top bit flags a quotient that saturates
  localparam int KickMulW  = 19;
  localparam int KickStep  = 23040;  // 90 px/s in Q16.8

  localparam int QueueDepth  = 4;
  localparam int FrontLat    = 6;
  localparam int BackMathLat = 8;
  localparam int BackLat     = BackMathLat + QuoW;

  typedef enum logic [CfgIdxW-1:0] {
    CfgStartX = 3'd0,
    CfgStartY = 3'd1,
    CfgEndX   = 3'd2,
    CfgEndY   = 3'd3,
    CfgRest   = 3'd4,
    CfgKick   = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic signed [PosW-1:0] start_x;
    logic signed [PosW-1:0] start_y;
    logic signed [PosW-1:0] end_x;
    logic signed [PosW-1:0] end_y;
    logic [RestW-1:0]       rest;
    logic [KickW-1:0]       kick;
  } cfg_t;

  // What the front hands to the back for one ball.
  typedef struct packed {
    logic                   hit;
    logic signed [VelW-1:0] vx;
    logic signed [VelW-1:0] vy;
    logic signed [DW-1:0]   dx;
    logic signed [DW-1:0]   dy;
    logic signed [TW-1:0]   t;
    logic signed [TW-1:0]   n;
    logic [DdW-1:0]         dd;
  } item_t;

  typedef struct packed {
    logic  push;
    item_t item;
  } push_t;

  typedef struct packed {
    logic  avail;
    item_t item;
  } head_t;

  typedef struct packed {
    logic                   hit;
    logic signed [VelW-1:0] vx;
    logic signed [VelW-1:0] vy;
  } side_t;

endpackage

// File: sv/sbb_ifs.sv
// Handshake channels of the bounce unit: ball words in, bounce words out,
// and register writes. Depends on sbb_pkg for the field widths.
interface sbb_ball_if;
  logic                            valid;
  logic                            ready;
  logic signed [sbb_pkg::PosW-1:0] pos_x;
  logic signed [sbb_pkg::PosW-1:0] pos_y;
  logic [sbb_pkg::RadW-1:0]        radius;
  logic signed [sbb_pkg::VelW-1:0] vel_x;
  logic signed [sbb_pkg::VelW-1:0] vel_y;
  modport source (output valid, pos_x, pos_y, radius, vel_x, vel_y, input ready);
  modport sink (input valid, pos_x, pos_y, radius, vel_x, vel_y, output ready);
endinterface

interface sbb_bounce_if;
  logic                            valid;
  logic                            ready;
  logic                            hit;
  logic signed [sbb_pkg::VelW-1:0] new_vel_x;
  logic signed [sbb_pkg::VelW-1:0] new_vel_y;
  modport source (output valid, hit, new_vel_x, new_vel_y, input ready);
  modport sink (input valid, hit, new_vel_x, new_vel_y, output ready);
endinterface

interface sbb_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [sbb_pkg::CfgIdxW-1:0]   index;
  logic [sbb_pkg::CfgDataW-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: sv/sbb_front.sv
// Front pipeline: takes ball words, forms the segment geometry and decides hits.
// Depends on sbb_pkg and sbb_ball_if; feeds sbb_fifo.
module sbb_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  sbb_pkg::cfg_t   cfg_i,
  sbb_ball_if.sink        ball_i,
  input  logic            full_i,
  output sbb_pkg::push_t  push_o
);

  localparam int Last = sbb_pkg::FrontLat - 1;

  logic [sbb_pkg::FrontLat-1:0] vld_q;
  logic                         adv;

  // Stage 0: differences.
  logic signed [sbb_pkg::DW-1:0]   px0_q, py0_q, qx0_q, qy0_q, dx0_q, dy0_q;
  logic signed [sbb_pkg::VelW-1:0] vx0_q, vy0_q;
  logic [sbb_pkg::RadW-1:0]        r0_q;
  // Stage 1: products.
  logic signed [sbb_pkg::ProdW-1:0]  pxdx1_q, pydy1_q, qxdx1_q, qydy1_q;
  logic signed [sbb_pkg::ProdW-1:0]  dxpy1_q, dypx1_q, dxdx1_q, dydy1_q;
  logic signed [sbb_pkg::VProdW-1:0] vxdx1_q, vydy1_q, vydx1_q, vxdy1_q;
  logic [sbb_pkg::RrW-1:0]           rr1_q;
  logic signed [sbb_pkg::DW-1:0]     dx1_q, dy1_q;
  logic signed [sbb_pkg::VelW-1:0]   vx1_q, vy1_q;
  // Stage 2: sums.
  logic signed [sbb_pkg::DotW-1:0] dotp2_q, dotq2_q, cross2_q;
  logic [sbb_pkg::DdW-1:0]         dd2_q;
  logic signed [sbb_pkg::TW-1:0]   t2_q, n2_q;
  logic [sbb_pkg::RrW-1:0]         rr2_q;
  logic signed [sbb_pkg::DW-1:0]   dx2_q, dy2_q;
  logic signed [sbb_pkg::VelW-1:0] vx2_q, vy2_q;
  // Stage 3: simple tests and cross magnitude.
  logic                            ok3_q;
  logic [sbb_pkg::CrW-1:0]         cr3_q;
  logic [sbb_pkg::DdW-1:0]         dd3_q;
  logic signed [sbb_pkg::TW-1:0]   t3_q, n3_q;
  logic [sbb_pkg::RrW-1:0]         rr3_q;
  logic signed [sbb_pkg::DW-1:0]   dx3_q, dy3_q;
  logic signed [sbb_pkg::VelW-1:0] vx3_q, vy3_q;
  // Stage 4: partial products of the squared distance test.
  logic                                           ok4_q;
  logic [2*sbb_pkg::HalfW-1:0]                    cchh4_q, cchl4_q, ccll4_q;
  logic [sbb_pkg::RrW+sbb_pkg::HalfW-1:0]         rdh4_q, rdl4_q;
  logic [sbb_pkg::DdW-1:0]                        dd4_q;
  logic signed [sbb_pkg::TW-1:0]                  t4_q, n4_q;
  logic signed [sbb_pkg::DW-1:0]                  dx4_q, dy4_q;
  logic signed [sbb_pkg::VelW-1:0]                vx4_q, vy4_q;
  // Stage 5: full squares.
  logic                            ok5_q;
  logic [sbb_pkg::Cr2W-1:0]        cr25_q;
  logic [sbb_pkg::RdW-1:0]         rd5_q;
  logic [sbb_pkg::DdW-1:0]         dd5_q;
  logic signed [sbb_pkg::TW-1:0]   t5_q, n5_q;
  logic signed [sbb_pkg::DW-1:0]   dx5_q, dy5_q;
  logic signed [sbb_pkg::VelW-1:0] vx5_q, vy5_q;

  logic signed [sbb_pkg::DW-1:0] sx, sy, ex, ey;
  logic                          sign_fail;
  logic [sbb_pkg::HalfW-1:0]     ch, cl;

  assign adv          = !vld_q[Last] || !full_i;
  assign ball_i.ready = adv;

  assign sx = sbb_pkg::DW'(cfg_i.start_x);
  assign sy = sbb_pkg::DW'(cfg_i.start_y);
  assign ex = sbb_pkg::DW'(cfg_i.end_x);
  assign ey = sbb_pkg::DW'(cfg_i.end_y);

  // Moving away means the velocity and the offset from the line lie on the same side.
  assign sign_fail = (n2_q > 0 && cross2_q > 0) || (n2_q < 0 && cross2_q < 0);

  assign ch = cr3_q[sbb_pkg::CrW-1:sbb_pkg::HalfW];
  assign cl = cr3_q[sbb_pkg::HalfW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[Last-1:0], ball_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      px0_q <= sbb_pkg::DW'(ball_i.pos_x) - sx;
      py0_q <= sbb_pkg::DW'(ball_i.pos_y) - sy;
      qx0_q <= sbb_pkg::DW'(ball_i.pos_x) - ex;
      qy0_q <= sbb_pkg::DW'(ball_i.pos_y) - ey;
      dx0_q <= ex - sx;
      dy0_q <= ey - sy;
      vx0_q <= ball_i.vel_x;
      vy0_q <= ball_i.vel_y;
      r0_q  <= ball_i.radius;

      pxdx1_q <= px0_q * dx0_q;
      pydy1_q <= py0_q * dy0_q;
      qxdx1_q <= qx0_q * dx0_q;
      qydy1_q <= qy0_q * dy0_q;
      dxpy1_q <= dx0_q * py0_q;
      dypx1_q <= dy0_q * px0_q;
      dxdx1_q <= dx0_q * dx0_q;
      dydy1_q <= dy0_q * dy0_q;
      vxdx1_q <= vx0_q * dx0_q;
      vydy1_q <= vy0_q * dy0_q;
      vydx1_q <= vy0_q * dx0_q;
      vxdy1_q <= vx0_q * dy0_q;
      rr1_q   <= r0_q * r0_q;
      dx1_q   <= dx0_q;
      dy1_q   <= dy0_q;
      vx1_q   <= vx0_q;
      vy1_q   <= vy0_q;

      dotp2_q  <= sbb_pkg::DotW'(pxdx1_q) + sbb_pkg::DotW'(pydy1_q);
      dotq2_q  <= sbb_pkg::DotW'(qxdx1_q) + sbb_pkg::DotW'(qydy1_q);
      cross2_q <= sbb_pkg::DotW'(dxpy1_q) - sbb_pkg::DotW'(dypx1_q);
      dd2_q    <= sbb_pkg::DdW'($unsigned(dxdx1_q)) + sbb_pkg::DdW'($unsigned(dydy1_q));
      t2_q     <= sbb_pkg::TW'(vxdx1_q) + sbb_pkg::TW'(vydy1_q);
      n2_q     <= sbb_pkg::TW'(vydx1_q) - sbb_pkg::TW'(vxdy1_q);
      rr2_q    <= rr1_q;
      dx2_q    <= dx1_q;
      dy2_q    <= dy1_q;
      vx2_q    <= vx1_q;
      vy2_q    <= vy1_q;

      ok3_q <= (dd2_q != '0) && (dotp2_q >= 0) && (dotq2_q <= 0) && !sign_fail;
      cr3_q <= cross2_q[sbb_pkg::DotW-1] ? sbb_pkg::CrW'(-cross2_q)
                                         : sbb_pkg::CrW'(cross2_q);
      dd3_q <= dd2_q;
      t3_q  <= t2_q;
      n3_q  <= n2_q;
      rr3_q <= rr2_q;
      dx3_q <= dx2_q;
      dy3_q <= dy2_q;
      vx3_q <= vx2_q;
      vy3_q <= vy2_q;

      ok4_q   <= ok3_q;
      cchh4_q <= ch * ch;
      cchl4_q <= ch * cl;
      ccll4_q <= cl * cl;
      rdh4_q  <= rr3_q * dd3_q[sbb_pkg::DdW-1:sbb_pkg::HalfW];
      rdl4_q  <= rr3_q * dd3_q[sbb_pkg::HalfW-1:0];
      dd4_q   <= dd3_q;
      t4_q    <= t3_q;
      n4_q    <= n3_q;
      dx4_q   <= dx3_q;
      dy4_q   <= dy3_q;
      vx4_q   <= vx3_q;
      vy4_q   <= vy3_q;

      ok5_q  <= ok4_q;
      cr25_q <= (sbb_pkg::Cr2W'(cchh4_q) << (2 * sbb_pkg::HalfW))
              + (sbb_pkg::Cr2W'(cchl4_q) << (sbb_pkg::HalfW + 1))
              + sbb_pkg::Cr2W'(ccll4_q);
      rd5_q  <= (sbb_pkg::RdW'(rdh4_q) << sbb_pkg::HalfW) + sbb_pkg::RdW'(rdl4_q);
      dd5_q  <= dd4_q;
      t5_q   <= t4_q;
      n5_q   <= n4_q;
      dx5_q  <= dx4_q;
      dy5_q  <= dy4_q;
      vx5_q  <= vx4_q;
      vy5_q  <= vy4_q;
    end
  end

  always_comb begin
    push_o.push      = vld_q[Last] && !full_i;
    push_o.item.hit  = ok5_q && (cr25_q < sbb_pkg::Cr2W'(rd5_q));
    push_o.item.vx   = vx5_q;
    push_o.item.vy   = vy5_q;
    push_o.item.dx   = dx5_q;
    push_o.item.dy   = dy5_q;
    push_o.item.t    = t5_q;
    push_o.item.n    = n5_q;
    push_o.item.dd   = dd5_q;
  end

endmodule

// File: sv/sbb_fifo.sv
// Short queue of classified balls between the front and back pipelines.
// Depends on sbb_pkg for the word type.
`include "assert_macros.svh"
module sbb_fifo #(
  parameter int Depth = sbb_pkg::QueueDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  sbb_pkg::push_t  push_i,
  output logic            full_o,
  input  logic            pop_i,
  output sbb_pkg::head_t  head_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);

  sbb_pkg::item_t  mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            empty;

  assign full_o = (cnt_q == CntW'(Depth));
  assign empty  = (cnt_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i.push) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_q + CntW'(push_i.push) - CntW'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.push) begin
      mem_q[wr_ptr_q] <= push_i.item;
    end
  end

  assign head_o.avail = !empty;
  assign head_o.item  = mem_q[rd_ptr_q];

  `SBB_ASSERT(a_no_overflow, push_i.push |-> !full_o, "queue written while full")
  `SBB_ASSERT(a_no_underflow, pop_i |-> !empty, "queue read while empty")
  `SBB_ASSERT_NEXT(a_cnt_track, 1'b1, cnt_q == $past(cnt_q) + CntW'($past(push_i.push)) - CntW'($past(pop_i)), "queue count out of step")

endmodule

// File: sv/sbb_div.sv
// Pipelined restoring divider: one quotient bit per stage, sign carried along.
// Depends on sbb_pkg for widths; used twice by sbb_back.
module sbb_div (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [sbb_pkg::RemW-1:0]      num_i,
  input  logic [sbb_pkg::DdW-1:0]       den_i,
  input  logic                          neg_i,
  output logic [sbb_pkg::QuoW-1:0]      quo_o,
  output logic                          neg_o
);

  localparam int RemW = sbb_pkg::RemW;
  localparam int DenW = sbb_pkg::DdW;
  localparam int QuoW = sbb_pkg::QuoW;

  logic [RemW-1:0] rem_q [QuoW];
  logic [DenW-1:0] den_q [QuoW];
  logic [QuoW-1:0] quo_q [QuoW];
  logic            neg_q [QuoW];

  for (genvar i = 0; i < QuoW; i++) begin : g_stage
    localparam int K = QuoW - 1 - i;
    logic [RemW-1:0] rem_in, den_sh;
    logic [DenW-1:0] den_in;
    logic [QuoW-1:0] quo_in;
    logic            neg_in;
    logic [RemW:0]   diff;

    if (i == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
      assign neg_in = neg_i;
    end else begin : g_next
      assign rem_in = rem_q[i-1];
      assign den_in = den_q[i-1];
      assign quo_in = quo_q[i-1];
      assign neg_in = neg_q[i-1];
    end

    assign den_sh = RemW'(den_in) << K;
    assign diff   = {1'b0, rem_in} - {1'b0, den_sh};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[i] <= den_in;
        neg_q[i] <= neg_in;
        if (!diff[RemW]) begin
          rem_q[i] <= diff[RemW-1:0];
          quo_q[i] <= quo_in | (QuoW'(1) << K);
        end else begin
          rem_q[i] <= rem_in;
          quo_q[i] <= quo_in;
        end
      end
    end
  end

  assign quo_o = quo_q[QuoW-1];
  assign neg_o = neg_q[QuoW-1];

endmodule

// File: sv/sbb_back.sv
// Back pipeline: reflects the velocity of hit balls and drives bounce words.
// Depends on sbb_pkg, sbb_bounce_if and sbb_div; reads sbb_fifo.
`include "assert_macros.svh"
module sbb_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  sbb_pkg::cfg_t   cfg_i,
  input  sbb_pkg::head_t  head_i,
  output logic            pop_o,
  sbb_bounce_if.source    bounce_o
);

  localparam int Last = sbb_pkg::BackLat - 1;
  localparam int HW   = sbb_pkg::HalfW;
  localparam int EPW  = 22;  // piece width when splitting the scaled normal part

  typedef logic signed [sbb_pkg::VelW-1:0] vel_t;

  function automatic vel_t sat_vel(input logic signed [28:0] v);
    vel_t r;
    if (v > 29'sd8388607) begin
      r = 24'sh7FFFFF;
    end else if (v < -29'sd8388608) begin
      r = 24'sh800000;
    end else begin
      r = v[sbb_pkg::VelW-1:0];
    end
    return r;
  endfunction

  logic [Last:0]         vld_q;
  sbb_pkg::side_t        side_q [sbb_pkg::BackLat];
  logic                  adv;

  sbb_pkg::item_t        it0_q;
  // Stage 1.
  logic signed [40:0]                  enh1_q;
  logic signed [41:0]                  enl1_q;
  logic signed [2*HW-1:0]              tdxh1_q, tdyh1_q;
  logic signed [2*HW:0]                tdxl1_q, tdyl1_q;
  logic signed [sbb_pkg::DW-1:0]       dx1_q, dy1_q;
  logic [sbb_pkg::DdW-1:0]             dd1_q;
  // Stage 2.
  logic signed [sbb_pkg::EnW-1:0]      en2_q;
  logic signed [sbb_pkg::TdW-1:0]      tdx2_q, tdy2_q;
  logic signed [sbb_pkg::DW-1:0]       dx2_q, dy2_q;
  logic [sbb_pkg::DdW-1:0]             dd2_q;
  // Stage 3.
  logic signed [47:0]                  edx03_q, edx13_q, edy03_q, edy13_q;
  logic signed [46:0]                  edx23_q, edy23_q;
  logic signed [sbb_pkg::TdW-1:0]      tdx3_q, tdy3_q;
  logic [sbb_pkg::DdW-1:0]             dd3_q;
  // Stage 4.
  logic signed [sbb_pkg::EdW-1:0]      edx4_q, edy4_q;
  logic signed [sbb_pkg::TdW-1:0]      tdx4_q, tdy4_q;
  logic [sbb_pkg::DdW-1:0]             dd4_q;
  // Stage 5.
  logic signed [sbb_pkg::NumW-1:0]     nx5_q, ny5_q;
  logic [sbb_pkg::DdW-1:0]             dd5_q;
  // Stage 6.
  logic [sbb_pkg::NumW-1:0]            mx6_q, my6_q;
  logic                                negx6_q, negy6_q;
  logic [sbb_pkg::DdW-1:0]             dd6_q;
  // Stage 7.
  logic [sbb_pkg::RemW-1:0]            mx7_q, my7_q;
  logic                                negx7_q, negy7_q;
  logic [sbb_pkg::DdW-1:0]             dd7_q;

  logic                                out_vld_q, out_hit_q;
  vel_t                                out_vx_q, out_vy_q;

  logic signed [sbb_pkg::RestW:0]      rest_s;
  logic signed [EPW:0]                 e0, e1;
  logic signed [EPW-1:0]               e2;
  logic [sbb_pkg::NumW:0]              rndx, rndy;
  logic [sbb_pkg::QuoW-1:0]            quox, quoy;
  logic                                negx, negy;
  logic [sbb_pkg::QuoW:0]              ux, uy;
  logic signed [sbb_pkg::QuoW+1:0]     svx, svy;
  logic [sbb_pkg::KickMulW-1:0]        kick_mul;
  logic signed [28:0]                  yk;

  assign adv   = !out_vld_q || bounce_o.ready;
  assign pop_o = adv && head_i.avail;

  assign rest_s = $signed({1'b0, cfg_i.rest});
  assign e0 = $signed({1'b0, en2_q[EPW-1:0]});
  assign e1 = $signed({1'b0, en2_q[2*EPW-1:EPW]});
  assign e2 = en2_q[sbb_pkg::EnW-1:2*EPW];

  // Adding half the divisor before dropping the 14 zero bits of the divisor
  // gives round half away from zero on the magnitude.
  assign rndx = sbb_pkg::NumW'(mx6_q) + ((sbb_pkg::NumW+1)'(dd6_q) << 13);
  assign rndy = sbb_pkg::NumW'(my6_q) + ((sbb_pkg::NumW+1)'(dd6_q) << 13);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vld_q     <= {vld_q[Last-1:0], pop_o};
      out_vld_q <= vld_q[Last];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q[0] <= '{hit: head_i.item.hit, vx: head_i.item.vx, vy: head_i.item.vy};
      for (int i = 1; i < sbb_pkg::BackLat; i++) begin
        side_q[i] <= side_q[i-1];
      end

      it0_q <= head_i.item;

      enh1_q  <= rest_s * $signed(it0_q.n[sbb_pkg::TW-1:HW]);
      enl1_q  <= rest_s * $signed({1'b0, it0_q.n[HW-1:0]});
      tdxh1_q <= $signed(it0_q.t[sbb_pkg::TW-1:HW]) * it0_q.dx;
      tdyh1_q <= $signed(it0_q.t[sbb_pkg::TW-1:HW]) * it0_q.dy;
      tdxl1_q <= $signed({1'b0, it0_q.t[HW-1:0]}) * it0_q.dx;
      tdyl1_q <= $signed({1'b0, it0_q.t[HW-1:0]}) * it0_q.dy;
      dx1_q   <= it0_q.dx;
      dy1_q   <= it0_q.dy;
      dd1_q   <= it0_q.dd;

      en2_q  <= (sbb_pkg::EnW'(enh1_q) <<< HW) + sbb_pkg::EnW'(enl1_q);
      tdx2_q <= (sbb_pkg::TdW'(tdxh1_q) <<< HW) + sbb_pkg::TdW'(tdxl1_q);
      tdy2_q <= (sbb_pkg::TdW'(tdyh1_q) <<< HW) + sbb_pkg::TdW'(tdyl1_q);
      dx2_q  <= dx1_q;
      dy2_q  <= dy1_q;
      dd2_q  <= dd1_q;

      edx03_q <= e0 * dx2_q;
      edx13_q <= e1 * dx2_q;
      edx23_q <= e2 * dx2_q;
      edy03_q <= e0 * dy2_q;
      edy13_q <= e1 * dy2_q;
      edy23_q <= e2 * dy2_q;
      tdx3_q  <= tdx2_q;
      tdy3_q  <= tdy2_q;
      dd3_q   <= dd2_q;

      edx4_q <= (sbb_pkg::EdW'(edx23_q) <<< (2 * EPW)) + (sbb_pkg::EdW'(edx13_q) <<< EPW)
              + sbb_pkg::EdW'(edx03_q);
      edy4_q <= (sbb_pkg::EdW'(edy23_q) <<< (2 * EPW)) + (sbb_pkg::EdW'(edy13_q) <<< EPW)
              + sbb_pkg::EdW'(edy03_q);
      tdx4_q <= tdx3_q;
      tdy4_q <= tdy3_q;
      dd4_q  <= dd3_q;

      nx5_q <= (sbb_pkg::NumW'(tdx4_q) <<< 14) + sbb_pkg::NumW'(edy4_q);
      ny5_q <= (sbb_pkg::NumW'(tdy4_q) <<< 14) - sbb_pkg::NumW'(edx4_q);
      dd5_q <= dd4_q;

      negx6_q <= nx5_q[sbb_pkg::NumW-1];
      negy6_q <= ny5_q[sbb_pkg::NumW-1];
      mx6_q   <= nx5_q[sbb_pkg::NumW-1] ? $unsigned(-nx5_q) : $unsigned(nx5_q);
      my6_q   <= ny5_q[sbb_pkg::NumW-1] ? $unsigned(-ny5_q) : $unsigned(ny5_q);
      dd6_q   <= dd5_q;

      mx7_q   <= rndx[sbb_pkg::NumW:14];
      my7_q   <= rndy[sbb_pkg::NumW:14];
      negx7_q <= negx6_q;
      negy7_q <= negy6_q;
      dd7_q   <= dd6_q;
    end
  end

  sbb_div u_div_x (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (mx7_q),
    .den_i (dd7_q),
    .neg_i (negx7_q),
    .quo_o (quox),
    .neg_o (negx)
  );

  sbb_div u_div_y (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (my7_q),
    .den_i (dd7_q),
    .neg_i (negy7_q),
    .quo_o (quoy),
    .neg_o (negy)
  );

  // A set top quotient bit means the magnitude is far past the 24-bit range.
  always_comb begin
    ux = quox[sbb_pkg::QuoW-1] ? (sbb_pkg::QuoW+1)'(1) << (sbb_pkg::QuoW-1)
                               : (sbb_pkg::QuoW+1)'(quox[sbb_pkg::QuoW-2:0]);
    uy = quoy[sbb_pkg::QuoW-1] ? (sbb_pkg::QuoW+1)'(1) << (sbb_pkg::QuoW-1)
                               : (sbb_pkg::QuoW+1)'(quoy[sbb_pkg::QuoW-2:0]);
    svx = negx ? -$signed({1'b0, ux}) : $signed({1'b0, ux});
    svy = negy ? -$signed({1'b0, uy}) : $signed({1'b0, uy});
    kick_mul = sbb_pkg::KickMulW'(cfg_i.kick) * sbb_pkg::KickMulW'(sbb_pkg::KickStep);
    yk = 29'(svy) - 29'($signed({1'b0, kick_mul}));
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_hit_q <= side_q[Last].hit;
      out_vx_q  <= side_q[Last].hit ? sat_vel(29'(svx)) : side_q[Last].vx;
      out_vy_q  <= side_q[Last].hit ? sat_vel(yk) : side_q[Last].vy;
    end
  end

  assign bounce_o.valid     = out_vld_q;
  assign bounce_o.hit       = out_hit_q;
  assign bounce_o.new_vel_x = out_vx_q;
  assign bounce_o.new_vel_y = out_vy_q;

  `SBB_ASSERT_NEXT(a_hold, !adv, $stable(vld_q) && $stable(out_vld_q), "back line moved while stalled")
  `SBB_ASSERT_NEXT(a_drain, adv && vld_q[Last], out_vld_q, "finished word lost at output")
  `SBB_ASSERT_NEXT(a_bubble, adv && !vld_q[Last], !out_vld_q, "output word invented")

endmodule

// File: sv/segment_ball_bounce_unit.sv
// Top level of the segment ball bounce unit: registers, front, queue and back.
// Depends on sbb_pkg, sbb_ifs, sbb_front, sbb_fifo, sbb_div and sbb_back.
//
//   channel    dir  word
//   ball_i     in   pos_x, pos_y, radius, vel_x, vel_y
//   bounce_o   out  hit, new_vel_x, new_vel_y
//   cfg_i      in   index, data (always ready)
//
// One word is taken every cycle unless a stall holds the front; every stage is a
// register after one multiply or one wide add, and the quotient comes from a
// 26-stage restoring divider. A result goes through the 6 front stages, the queue
// and the 34 back stages ahead of the output register.
// Reset loads the register defaults and empties every stage and the queue.
// A stalled output freezes the back; the queue then fills and holds the front.
module segment_ball_bounce_unit #(
  parameter int QueueDepth = sbb_pkg::QueueDepth
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  sbb_ball_if.sink     ball_i,
  sbb_bounce_if.source bounce_o,
  sbb_cfg_if.sink      cfg_i
);

  sbb_pkg::cfg_t  cfg_q;
  sbb_pkg::push_t push;
  sbb_pkg::head_t head;
  logic           full;
  logic           pop;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_x <= '0;
      cfg_q.start_y <= '0;
      cfg_q.end_x   <= 24'sd256;
      cfg_q.end_y   <= '0;
      cfg_q.rest    <= 15'd16384;
      cfg_q.kick    <= '0;
    end else if (cfg_i.valid) begin
      unique case (sbb_pkg::cfg_idx_e'(cfg_i.index))
        sbb_pkg::CfgStartX: cfg_q.start_x <= cfg_i.data;
        sbb_pkg::CfgStartY: cfg_q.start_y <= cfg_i.data;
        sbb_pkg::CfgEndX:   cfg_q.end_x   <= cfg_i.data;
        sbb_pkg::CfgEndY:   cfg_q.end_y   <= cfg_i.data;
        sbb_pkg::CfgRest:   cfg_q.rest    <= cfg_i.data[sbb_pkg::RestW-1:0];
        sbb_pkg::CfgKick:   cfg_q.kick    <= cfg_i.data[sbb_pkg::KickW-1:0];
        default: begin
        end
      endcase
    end
  end

  sbb_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .ball_i (ball_i),
    .full_i (full),
    .push_o (push)
  );

  sbb_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (full),
    .pop_i  (pop),
    .head_o (head)
  );

  sbb_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .head_i   (head),
    .pop_o    (pop),
    .bounce_o (bounce_o)
  );

endmodule
